[hw/rtl/dgt_pkg.sv]
`default_nettype none

package dgt_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int DEPTH_W       = 16;
  localparam int VID_W         = 18;
  localparam int TRI_W         = 19;
  localparam int CFG_W         = 10;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 10'd512;

  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [VID_W-1:0]   vid_t;
  typedef logic [TRI_W-1:0]   tri_num_t;
  typedef logic [CFG_W-1:0]   row_width_t;

  typedef enum logic [1:0] {
    TRI_NONE,
    TRI_ONE,
    TRI_TWO
  } tri_cnt_t;

  // One pixel as kept in the row store and in the neighbor registers
  typedef struct packed {
    logic   valid;
    depth_t depth;
    vid_t   vid;
  } pix_t;

  typedef struct packed {
    vid_t a;
    vid_t b;
    vid_t c;
  } tri_t;

  // Pixel leaving the front stage
  typedef struct packed {
    logic quad_en;
    logic fs;
    pix_t pix;
  } s1_t;

  // Triangles caused by one pixel
  typedef struct packed {
    tri_cnt_t n;
    tri_t     t0;
    tri_t     t1;
    tri_num_t tn0;
  } quad_res_t;

  function automatic depth_t abs_diff(input depth_t x, input depth_t y);
    abs_diff = (x > y) ? depth_t'(x - y) : depth_t'(y - x);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dgt_in_if.sv]
`default_nettype none

interface dgt_in_if import dgt_pkg::*; ();
  logic   valid;
  logic   ready;
  depth_t depth_value;
  logic   frame_start;

  modport source (output valid, output depth_value, output frame_start, input ready);
  modport sink   (input valid, input depth_value, input frame_start, output ready);
endinterface

`default_nettype wire

[hw/rtl/dgt_out_if.sv]
`default_nettype none

interface dgt_out_if import dgt_pkg::*; ();
  logic     valid;
  logic     ready;
  vid_t     vertex_a;
  vid_t     vertex_b;
  vid_t     vertex_c;
  tri_num_t triangle_number;
  logic     last_of_run;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output triangle_number, output last_of_run, input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input triangle_number, input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/dgt_front.sv]
`default_nettype none

module dgt_front import dgt_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dgt_in_if.sink          in_chan,
  input  wire logic       cfg_we,
  input  wire row_width_t cfg_wdata,
  output logic            s1_valid,
  output s1_t             s1,
  output pix_t            up_pix,
  input  wire logic       s1_take
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W + 1;

  pix_t             mem [MAX_WIDTH];
  pix_t             rd_r;
  row_width_t       row_width_r;
  logic [CW-1:0]    col_r;
  logic             first_r;
  vid_t             vcnt_r;
  logic             s1_valid_r;
  s1_t              s1_r;

  logic             acc;
  logic [CW-1:0]    col;
  logic             first;
  vid_t             vbase;
  pix_t             cur;
  logic [WW-1:0]    rw_ext;
  logic [WW-1:0]    w_eff;
  logic [WW-1:0]    col_inc;
  logic             wrap;
  logic [CW-1:0]    col_nxt;

  assign in_chan.ready = !s1_valid_r || s1_take;
  assign acc           = in_chan.valid && in_chan.ready;

  // frame start clears position and counters before the pixel is used
  assign col   = in_chan.frame_start ? '0 : col_r;
  assign first = in_chan.frame_start ? 1'b1 : first_r;
  assign vbase = in_chan.frame_start ? '0 : vcnt_r;

  always_comb begin
    cur.depth = in_chan.depth_value;
    cur.valid = (in_chan.depth_value != '0);
    cur.vid   = vbase;
  end

  always_comb begin
    rw_ext = WW'(row_width_r);
    if (rw_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (rw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
    col_inc = WW'(col) + WW'(1);
    wrap    = (col_inc >= w_eff);
    col_nxt = wrap ? '0 : col_inc[CW-1:0];
  end

  // row store: read the pixel above, overwrite it with the current one
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[col] <= cur;
      rd_r     <= mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.pix     <= cur;
      s1_r.fs      <= in_chan.frame_start;
      s1_r.quad_en <= !first && (col != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      col_r       <= '0;
      first_r     <= 1'b1;
      vcnt_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width_r <= cfg_wdata;
      end
      if (acc) begin
        col_r      <= col_nxt;
        first_r    <= wrap ? 1'b0 : first;
        vcnt_r     <= vbase + VID_W'(cur.valid);
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign up_pix   = rd_r;

endmodule

`default_nettype wire

[hw/rtl/dgt_quad.sv]
`default_nettype none

module dgt_quad import dgt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic s1_valid,
  input  wire s1_t  s1,
  input  wire pix_t up_pix,
  output logic      s1_take,
  output logic      res_valid,
  output quad_res_t res,
  input  wire logic res_ready
);

  pix_t     tl_r;
  pix_t     bl_r;
  tri_num_t tcnt_r;

  pix_t       tl, tr, bl, br;
  logic [2:0] cnt;
  depth_t     d_main;
  depth_t     d_anti;

  function automatic tri_t mk_tri(input vid_t a, input vid_t b, input vid_t c);
    mk_tri.a = a;
    mk_tri.b = b;
    mk_tri.c = c;
  endfunction

  assign tl = tl_r;
  assign tr = up_pix;
  assign bl = bl_r;
  assign br = s1.pix;

  assign cnt    = 3'(tl.valid) + 3'(tr.valid) + 3'(bl.valid) + 3'(br.valid);
  assign d_main = abs_diff(tl.depth, br.depth);
  assign d_anti = abs_diff(tr.depth, bl.depth);

  always_comb begin
    res.n   = TRI_NONE;
    res.t0  = mk_tri(tl.vid, tr.vid, bl.vid);
    res.t1  = mk_tri(tr.vid, br.vid, bl.vid);
    res.tn0 = s1.fs ? '0 : tcnt_r;
    if (s1.quad_en) begin
      case (cnt)
        3'd4: begin
          res.n = TRI_TWO;
          // split along the diagonal with the smaller depth step
          if (d_main < d_anti) begin
            res.t0 = mk_tri(tl.vid, br.vid, bl.vid);
            res.t1 = mk_tri(tl.vid, tr.vid, br.vid);
          end
        end
        3'd3: begin
          res.n = TRI_ONE;
          if (!tl.valid) begin
            res.t0 = mk_tri(tr.vid, br.vid, bl.vid);
          end else if (!tr.valid) begin
            res.t0 = mk_tri(tl.vid, br.vid, bl.vid);
          end else if (!bl.valid) begin
            res.t0 = mk_tri(tl.vid, tr.vid, br.vid);
          end else begin
            res.t0 = mk_tri(tl.vid, tr.vid, bl.vid);
          end
        end
        default: res.n = TRI_NONE;
      endcase
    end
  end

  assign res_valid = s1_valid && (res.n != TRI_NONE);
  assign s1_take   = s1_valid && ((res.n == TRI_NONE) || res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r   <= '0;
      bl_r   <= '0;
      tcnt_r <= '0;
    end else if (s1_take) begin
      tl_r   <= up_pix;
      bl_r   <= s1.pix;
      tcnt_r <= res.tn0 + TRI_W'(res.n);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dgt_emit.sv]
`default_nettype none

module dgt_emit import dgt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire quad_res_t res,
  output logic           res_ready,
  dgt_out_if.source      out_chan
);

  quad_res_t pend_r;
  logic      pend_valid_r;
  logic      pend_idx_r;
  logic      out_valid_r;
  tri_t      out_tri_r;
  tri_num_t  out_num_r;
  logic      out_last_r;

  logic      out_load;
  logic      pend_last;

  assign out_load  = !out_valid_r || out_chan.ready;
  assign pend_last = (pend_r.n == TRI_ONE) || pend_idx_r;
  assign res_ready = !pend_valid_r || (pend_last && out_load);

  always_ff @(posedge clk) begin
    if (out_load && pend_valid_r) begin
      out_tri_r  <= pend_idx_r ? pend_r.t1 : pend_r.t0;
      out_num_r  <= pend_r.tn0 + TRI_W'(pend_idx_r);
      out_last_r <= pend_last;
    end
    if (res_valid && res_ready) begin
      pend_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_idx_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= pend_valid_r;
      end
      // a new request replaces the one that drains this cycle
      if (res_valid && res_ready) begin
        pend_valid_r <= 1'b1;
        pend_idx_r   <= 1'b0;
      end else if (out_load && pend_valid_r) begin
        if (pend_last) begin
          pend_valid_r <= 1'b0;
          pend_idx_r   <= 1'b0;
        end else begin
          pend_idx_r <= 1'b1;
        end
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.vertex_a        = out_tri_r.a;
  assign out_chan.vertex_b        = out_tri_r.b;
  assign out_chan.vertex_c        = out_tri_r.c;
  assign out_chan.triangle_number = out_num_r;
  assign out_chan.last_of_run     = out_last_r;

  ap_idx_two: assert property (@(posedge clk) disable iff (!rst_n)
    pend_idx_r |-> pend_valid_r && (pend_r.n == TRI_TWO))
    else $error("second triangle pending without a pair");

  ap_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_r.n != TRI_NONE))
    else $error("pending entry holds no triangle");

  ap_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last_of_run |=>
      out_chan.valid && out_chan.last_of_run &&
      (out_chan.triangle_number == TRI_W'($past(out_chan.triangle_number) + 1'b1)))
    else $error("second triangle of a pair did not follow");

endmodule

`default_nettype wire

[hw/rtl/depth_grid_triangulation_top.sv]
// channel | dir | payload                                                  | handshake
// in_chan | in  | depth_value[15:0], frame_start                           | valid/ready
// out_chan| out | vertex_a/b/c[17:0], triangle_number[18:0], last_of_run   | valid/ready
// cfg     | in  | cfg_wdata[9:0] = row_width                               | cfg_we
//
// One pixel per cycle while pixels give at most one triangle and out_chan does not stall;
// a pixel giving two triangles holds back later pixels until its second one is loaded, since
// out_chan carries one triangle per cycle. A pixel's first triangle passes through the front
// stage register, the pending entry and the output register before it is valid on out_chan.
// The row store is a one-port-write, one-read memory; it is not cleared at reset.
// A stall on out_chan backs up through the pending pair and the front stage to in_chan.
`default_nettype none

module depth_grid_triangulation_top import dgt_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dgt_in_if.sink          in_chan,
  dgt_out_if.source       out_chan,
  input  wire logic       cfg_we,
  input  wire row_width_t cfg_wdata
);

  logic      s1_valid;
  s1_t       s1;
  pix_t      up_pix;
  logic      s1_take;
  logic      res_valid;
  quad_res_t res;
  logic      res_ready;

  dgt_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .up_pix    (up_pix),
    .s1_take   (s1_take)
  );

  dgt_quad u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .up_pix    (up_pix),
    .s1_take   (s1_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  dgt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dgt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAX_W       = MAX_WIDTH_DEF;
  localparam int DRAIN_PAD   = 8;
  localparam int END_WAIT    = 20000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int QUEUE_CAP   = 64;
  localparam int DIR_LEN     = 21;
  localparam int DIR_RESTART = 15;
  localparam int N_PHASES    = 12;
  // dense pixels at the end of the run, several rows at width 16
  localparam int BULK_PX     = 80;

  typedef struct {
    depth_t depth;
    logic   fs;
  } px_req_t;

  typedef struct {
    vid_t     a;
    vid_t     b;
    vid_t     c;
    tri_num_t num;
    logic     last;
  } tri_exp_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  row_width_t cfg_wdata;

  dgt_in_if  in_chan ();
  dgt_out_if out_chan ();

  depth_grid_triangulation_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // mesh predictor state
  pix_t        row_mem [MAX_W];
  pix_t        left_px;
  pix_t        upleft_px;
  int unsigned col_pos;
  bit          first_row;
  vid_t        vtx_cnt;
  tri_num_t    tri_cnt;
  row_width_t  width_reg;
  int unsigned cols_written;

  px_req_t     pending_px [$];
  tri_exp_t    tri_due [$];
  int unsigned px_sent;
  int unsigned px_taken;
  int unsigned tris_checked;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          idle_on;
  depth_t      near_base;
  depth_t      dir_px [DIR_LEN];
  row_width_t  phase_w [N_PHASES];

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic int unsigned eff_width(input row_width_t w);
    if (w < 2) return 2;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned depth_gap(input depth_t x, input depth_t y);
    if (x > y) return x - y;
    return y - x;
  endfunction

  function automatic tri_exp_t make_tri(input vid_t a, input vid_t b, input vid_t c);
    tri_exp_t t;
    t.a    = a;
    t.b    = b;
    t.c    = c;
    t.num  = tri_cnt;
    t.last = 1'b0;
    tri_cnt = tri_cnt + 1'b1;
    return t;
  endfunction

  // Advance the mesh by one pixel and queue the triangles it closes
  function automatic void mesh_step(input depth_t d, input logic fs);
    pix_t        cur;
    pix_t        up;
    pix_t        tl;
    pix_t        tr;
    pix_t        bl;
    pix_t        br;
    int unsigned col;
    int unsigned w;
    int unsigned nvalid;
    int unsigned n;
    tri_exp_t    res [2];
    if (fs) begin
      vtx_cnt   = '0;
      tri_cnt   = '0;
      col_pos   = 0;
      first_row = 1'b1;
    end
    w   = eff_width(width_reg);
    col = col_pos;
    cur.depth = d;
    cur.valid = (d != 0);
    cur.vid   = vtx_cnt;
    if (cur.valid) vtx_cnt = vtx_cnt + 1'b1;
    up = row_mem[col];
    n  = 0;
    if (!first_row && col != 0) begin
      tl = upleft_px;
      tr = up;
      bl = left_px;
      br = cur;
      nvalid = int'(tl.valid) + int'(tr.valid) + int'(bl.valid) + int'(br.valid);
      if (nvalid == 4) begin
        // split along the diagonal with the smaller depth step
        if (depth_gap(tl.depth, br.depth) < depth_gap(tr.depth, bl.depth)) begin
          res[0] = make_tri(tl.vid, br.vid, bl.vid);
          res[1] = make_tri(tl.vid, tr.vid, br.vid);
        end else begin
          res[0] = make_tri(tl.vid, tr.vid, bl.vid);
          res[1] = make_tri(tr.vid, br.vid, bl.vid);
        end
        n = 2;
      end else if (nvalid == 3) begin
        if (!tl.valid)      res[0] = make_tri(tr.vid, br.vid, bl.vid);
        else if (!tr.valid) res[0] = make_tri(tl.vid, br.vid, bl.vid);
        else if (!bl.valid) res[0] = make_tri(tl.vid, tr.vid, br.vid);
        else                res[0] = make_tri(tl.vid, tr.vid, bl.vid);
        n = 1;
      end
      for (int unsigned i = 0; i < n; i++) begin
        res[i].last = (i == n - 1);
        tri_due.push_back(res[i]);
      end
    end
    upleft_px    = up;
    left_px      = cur;
    row_mem[col] = cur;
    if (col + 1 > cols_written) cols_written = col + 1;
    if (col + 1 >= w) begin
      col_pos   = 0;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  function automatic depth_t pick_depth();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18) return '0;
    if (r < 26) return '1;
    // clustered depths make ties between the two diagonals likely
    if (r < 66) return depth_t'(near_base + $urandom_range(0, 3));
    return depth_t'($urandom);
  endfunction

  task automatic send_px(input depth_t d, input logic fs);
    px_req_t px;
    px.depth = d;
    px.fs    = fs;
    while (pending_px.size() >= QUEUE_CAP) @(posedge clk);
    pending_px.push_back(px);
    px_sent++;
  endtask

  // Hold until every request is taken and every triangle has come back
  task automatic drain_mesh();
    while (px_taken != px_sent || tri_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_row_width(input row_width_t w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg = w;
  endtask

  task automatic run_phase(input row_width_t w, input int unsigned count, input bit force_fs);
    bit          fs_now;
    int unsigned k;
    drain_mesh();
    write_row_width(w);
    // a wider row must start a new frame unless those columns were stored before
    fs_now    = force_fs || (eff_width(w) > cols_written);
    near_base = depth_t'($urandom_range(1, 65000));
    for (k = 0; k < count; k++)
      send_px(pick_depth(), (k == 0 && fs_now) || ($urandom_range(0, 99) < 2));
  endtask

  // pixel driver
  always @(posedge clk) begin : drv
    px_req_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        mesh_step(in_chan.depth_value, in_chan.frame_start);
        px_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 12) begin
          gap_left = $urandom_range(0, 7);
          in_chan.valid <= 1'b0;
        end else if (pending_px.size() != 0) begin
          nxt = pending_px.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.depth_value <= nxt.depth;
          in_chan.frame_start <= nxt.fs;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // triangle monitor
  always @(posedge clk) begin : mon
    tri_exp_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (tri_due.size() == 0) begin
          flag_error($sformatf("triangle %0d arrived with no pixel behind it",
                               out_chan.triangle_number));
        end else begin
          want = tri_due.pop_front();
          tris_checked++;
          check_field("vertex_a", out_chan.vertex_a, want.a);
          check_field("vertex_b", out_chan.vertex_b, want.b);
          check_field("vertex_c", out_chan.vertex_c, want.c);
          check_field("triangle_number", out_chan.triangle_number, want.num);
          check_field("last_of_run", out_chan.last_of_run, want.last);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned cnt;
    int unsigned waited;
    int unsigned i;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_chan.valid       = 1'b0;
    in_chan.depth_value = '0;
    in_chan.frame_start = 1'b0;
    out_chan.ready      = 1'b0;
    left_px      = '0;
    upleft_px    = '0;
    col_pos      = 0;
    first_row    = 1'b1;
    vtx_cnt      = '0;
    tri_cnt      = '0;
    width_reg    = ROW_WIDTH_RST;
    cols_written = 0;
    px_sent      = 0;
    px_taken     = 0;
    tris_checked = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    idle_on      = 1'b1;
    near_base    = '0;
    // width 3: both splits, ties, each missing corner, a frame restart
    dir_px = '{16'd100, 16'd65535, 16'd0,
               16'd200, 16'd1,     16'd50,
               16'd0,   16'd301,   16'd50,
               16'd10,  16'd20,    16'd0,
               16'd20,  16'd10,    16'd5,
               16'd9,   16'd65535, 16'd9,
               16'd65535, 16'd1,   16'd9};
    phase_w = '{10'd2, 10'd0, 10'd1, 10'd5, 10'd4, 10'd1023,
                10'd512, 10'd6, 10'd9, 10'd3, 10'd16, 10'd7};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    drain_mesh();
    write_row_width(10'd3);
    for (i = 0; i < DIR_LEN; i++)
      send_px(dir_px[i], (i == 0) || (i == DIR_RESTART));

    for (p = 0; p < N_PHASES; p++) begin
      idle_on = (p % 3 != 2);
      if (phase_w[p] == 10'd512) cnt = 20;
      else                       cnt = $urandom_range(20, 30);
      // the full-width phase stops mid-row; the next one narrows the row under it
      run_phase(phase_w[p], cnt, phase_w[p] == 10'd512);
    end

    // dense frame, no idling on either side
    drain_mesh();
    idle_on = 1'b0;
    write_row_width(10'd16);
    for (i = 0; i < BULK_PX; i++)
      send_px(depth_t'($urandom_range(1, 65535)), i == 0);

    waited = 0;
    while ((px_taken != px_sent || tri_due.size() != 0) && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_PAD) @(posedge clk);
    if (px_taken != px_sent || tri_due.size() != 0)
      flag_error($sformatf("%0d pixels not taken, %0d triangles never came",
                           px_sent - px_taken, tri_due.size()));

    $display("Checked %0d triangles from %0d pixels over %0d row width settings",
             tris_checked, px_taken, N_PHASES + 2);
    $display("Out-of-range widths, mid-row narrowing, frame restarts and a dense frame ran");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dgt_pkg.sv
hw/rtl/dgt_in_if.sv
hw/rtl/dgt_out_if.sv
hw/rtl/dgt_front.sv
hw/rtl/dgt_quad.sv
hw/rtl/dgt_emit.sv
hw/rtl/depth_grid_triangulation_top.sv
bench/testbench.sv
